@@ hdl/jcse_pkg.sv @@
// ----------------------------------------------------------------------------
// jcse_pkg
// Shared types, constants and helper functions of the JPEG coefficient
// symbol encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jcse_pkg;

   localparam int COEFF_BITS = 12;
   localparam int DIFF_BITS  = COEFF_BITS + 1;
   localparam int POS_BITS   = 6;
   localparam int SIZE_BITS  = 4;
   localparam int SYM_BITS   = 8;

   localparam logic [SYM_BITS-1:0] SYM_ZRL  = 8'hF0;
   localparam logic [SYM_BITS-1:0] SYM_EOB  = 8'h00;
   localparam logic [POS_BITS-1:0] LAST_POS = 6'd63;

   // Coefficient held in the input register together with block context.
   typedef struct packed {
      logic signed [COEFF_BITS-1:0] coefficient;
      logic signed [COEFF_BITS-1:0] dc_prediction;
      logic                         at_dc;
      logic                         at_end;
      logic [POS_BITS-1:0]          run;
   } stage_type;

   // Everything one item produces: leading ZRLs and one closing symbol.
   typedef struct packed {
      logic                   has_result;
      logic [1:0]             zrl_count;
      logic [SYM_BITS-1:0]    symbol;
      logic                   is_dc;
      logic [COEFF_BITS-1:0]  extra_bits;
      logic [SIZE_BITS-1:0]   extra_length;
   } symbol_set_type;

   // Size category: position of the highest set bit plus one.
   function automatic logic [SIZE_BITS-1:0] size_of(input logic [COEFF_BITS-1:0] mag);
      logic [SIZE_BITS-1:0] s;
      s = '0;
      for (int i = 0; i < COEFF_BITS; i++) begin
         if (mag[i]) begin
            s = SIZE_BITS'(i + 1);
         end
      end
      return s;
   endfunction

   // Low sz bits set.
   function automatic logic [COEFF_BITS-1:0] low_mask(input logic [SIZE_BITS-1:0] sz);
      logic [COEFF_BITS-1:0] m;
      m = '0;
      for (int i = 0; i < COEFF_BITS; i++) begin
         m[i] = (SIZE_BITS'(i) < sz);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

@@ hdl/jpeg_coefficient_symbol_encoder_top.sv @@
// An item is taken into the input register, classified combinationally and
// loaded into the result register once that register is free.
// Throughput: one item per cycle unless the result register is busy; an item
// waits until its results are taken (up to four: three ZRLs and a symbol).
// Zero AC items inside a block produce nothing and pass without stalling.
// Reset (synchronous) empties both registers and restarts at block position 0.
// ----------------------------------------------------------------------------
// jpeg_coefficient_symbol_encoder_top
// JPEG baseline DC/AC run-length and size-category symbol encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_coefficient_symbol_encoder_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [jcse_pkg::COEFF_BITS-1:0] req_coefficient,
   input  wire logic signed [jcse_pkg::COEFF_BITS-1:0] req_dc_prediction,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [jcse_pkg::SYM_BITS-1:0]               rsp_symbol,
   output logic                                        rsp_is_dc,
   output logic [jcse_pkg::COEFF_BITS-1:0]             rsp_extra_bits,
   output logic [jcse_pkg::SIZE_BITS-1:0]              rsp_extra_length,
   output logic                                        rsp_last_of_run
);

   logic                      stage_valid;
   logic                      stage_taken;
   jcse_pkg::stage_type       stage;
   jcse_pkg::symbol_set_type  set;

   jcse_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_coefficient   (req_coefficient),
      .req_dc_prediction (req_dc_prediction),
      .stage_valid       (stage_valid),
      .stage             (stage),
      .stage_taken       (stage_taken)
   );

   jcse_classify u_classify (
      .stage (stage),
      .set   (set)
   );

   jcse_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .set_valid        (stage_valid),
      .set              (set),
      .set_taken        (stage_taken),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_is_dc        (rsp_is_dc),
      .rsp_extra_bits   (rsp_extra_bits),
      .rsp_extra_length (rsp_extra_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire

@@ hdl/jcse_front.sv @@
// ----------------------------------------------------------------------------
// jcse_front
// Input register plus block position and zero-run tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module jcse_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [jcse_pkg::COEFF_BITS-1:0] req_coefficient,
   input  wire logic signed [jcse_pkg::COEFF_BITS-1:0] req_dc_prediction,
   output logic                                        stage_valid,
   output jcse_pkg::stage_type                         stage,
   input  wire logic                                   stage_taken
);

   logic                            stage_valid_ff, stage_valid_in;
   jcse_pkg::stage_type             stage_ff, stage_in;
   logic [jcse_pkg::POS_BITS-1:0]   position_ff, position_in;
   logic [jcse_pkg::POS_BITS-1:0]   zero_run_ff, zero_run_in;
   logic                            req_fire;
   logic                            coeff_zero;

   assign req_ready   = !stage_valid_ff || stage_taken;
   assign req_fire    = req_valid && req_ready;
   assign coeff_zero  = (req_coefficient == '0);
   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   always_comb begin
      position_in    = position_ff;
      zero_run_in    = zero_run_ff;
      stage_valid_in = stage_valid_ff && !stage_taken;
      stage_in       = stage_ff;
      if (req_fire) begin
         position_in            = position_ff + 1'b1;
         stage_valid_in         = 1'b1;
         stage_in.coefficient   = req_coefficient;
         stage_in.dc_prediction = req_dc_prediction;
         stage_in.at_dc         = (position_ff == '0);
         stage_in.at_end        = (position_ff == jcse_pkg::LAST_POS);
         stage_in.run           = zero_run_ff;
         if (position_ff == '0 || !coeff_zero || position_ff == jcse_pkg::LAST_POS) begin
            zero_run_in = '0;
         end else begin
            zero_run_in = zero_run_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         position_ff    <= '0;
         zero_run_ff    <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         position_ff    <= position_in;
         zero_run_ff    <= zero_run_in;
      end
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

@@ hdl/jcse_classify.sv @@
// ----------------------------------------------------------------------------
// jcse_classify
// Size category, magnitude index and symbol byte for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module jcse_classify (
   input  wire jcse_pkg::stage_type  stage,
   output jcse_pkg::symbol_set_type  set
);

   logic signed [jcse_pkg::DIFF_BITS-1:0]  value;
   logic signed [jcse_pkg::DIFF_BITS-1:0]  value_m1;
   logic [jcse_pkg::DIFF_BITS-1:0]         abs_value;
   logic [jcse_pkg::COEFF_BITS-1:0]        mag;
   logic [jcse_pkg::SIZE_BITS-1:0]         sz;
   logic [jcse_pkg::COEFF_BITS-1:0]        index;
   logic                                   negative;

   always_comb begin
      if (stage.at_dc) begin
         value = jcse_pkg::DIFF_BITS'(stage.coefficient)
               - jcse_pkg::DIFF_BITS'(stage.dc_prediction);
      end else begin
         value = jcse_pkg::DIFF_BITS'(stage.coefficient);
      end
      negative  = value[jcse_pkg::DIFF_BITS-1];
      abs_value = negative ? jcse_pkg::DIFF_BITS'(-value) : value;
      mag       = abs_value[jcse_pkg::COEFF_BITS-1:0];
      sz        = jcse_pkg::size_of(mag);
      // ones'-complement index of a negative value is v-1 in sz bits
      value_m1  = value - jcse_pkg::DIFF_BITS'(1);
      index     = negative ? (value_m1[jcse_pkg::COEFF_BITS-1:0] & jcse_pkg::low_mask(sz))
                           : mag;

      set.has_result   = 1'b1;
      set.zrl_count    = '0;
      set.is_dc        = 1'b0;
      set.symbol       = jcse_pkg::SYM_EOB;
      set.extra_bits   = '0;
      set.extra_length = '0;
      if (stage.at_dc) begin
         set.is_dc        = 1'b1;
         set.symbol       = jcse_pkg::SYM_BITS'(sz);
         set.extra_bits   = index;
         set.extra_length = sz;
      end else if (stage.coefficient == '0) begin
         set.has_result = stage.at_end;
      end else begin
         set.zrl_count    = stage.run[5:4];
         set.symbol       = {stage.run[3:0], sz};
         set.extra_bits   = index;
         set.extra_length = sz;
      end
   end

endmodule

`default_nettype wire

@@ hdl/jcse_emit.sv @@
// ----------------------------------------------------------------------------
// jcse_emit
// Result register and sequencer: plays out pending ZRLs, then the closing
// symbol of the item.
// ----------------------------------------------------------------------------
`default_nettype none

module jcse_emit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             set_valid,
   input  wire jcse_pkg::symbol_set_type         set,
   output logic                                  set_taken,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [jcse_pkg::SYM_BITS-1:0]         rsp_symbol,
   output logic                                  rsp_is_dc,
   output logic [jcse_pkg::COEFF_BITS-1:0]       rsp_extra_bits,
   output logic [jcse_pkg::SIZE_BITS-1:0]        rsp_extra_length,
   output logic                                  rsp_last_of_run
);

   logic                       valid_ff, valid_in;
   logic [1:0]                 zrl_left_ff, zrl_left_in;
   jcse_pkg::symbol_set_type   held_ff, held_in;
   logic                       rsp_fire;
   logic                       final_done;
   logic                       load_ok;
   logic                       in_zrl;

   assign in_zrl     = (zrl_left_ff != '0);
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign final_done = rsp_fire && !in_zrl;
   assign load_ok    = !valid_ff || final_done;
   // items without a result are dropped here without waiting
   assign set_taken  = set_valid && (load_ok || !set.has_result);

   always_comb begin
      valid_in    = valid_ff && !final_done;
      zrl_left_in = zrl_left_ff;
      held_in     = held_ff;
      if (rsp_fire && in_zrl) begin
         zrl_left_in = zrl_left_ff - 1'b1;
      end
      if (set_valid && set.has_result && load_ok) begin
         valid_in    = 1'b1;
         zrl_left_in = set.zrl_count;
         held_in     = set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         zrl_left_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         zrl_left_ff <= zrl_left_in;
      end
      held_ff <= held_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_symbol       = in_zrl ? jcse_pkg::SYM_ZRL : held_ff.symbol;
   assign rsp_is_dc        = in_zrl ? 1'b0 : held_ff.is_dc;
   assign rsp_extra_bits   = in_zrl ? '0 : held_ff.extra_bits;
   assign rsp_extra_length = in_zrl ? '0 : held_ff.extra_length;
   assign rsp_last_of_run  = !in_zrl;

endmodule

`default_nettype wire

@@ hdl/jcse_checker.sv @@
// ----------------------------------------------------------------------------
// jcse_checker
// Port-level checks of the symbol encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jcse_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic [jcse_pkg::SYM_BITS-1:0]      rsp_symbol,
   input  wire logic                               rsp_is_dc,
   input  wire logic [jcse_pkg::COEFF_BITS-1:0]    rsp_extra_bits,
   input  wire logic [jcse_pkg::SIZE_BITS-1:0]     rsp_extra_length,
   input  wire logic                               rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol)
         && $stable(rsp_extra_bits) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   a_dc_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_dc |-> rsp_last_of_run && (rsp_symbol[7:4] == 4'd0))
      else $error("DC result not a lone category");

   a_zrl_leads: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_dc && rsp_symbol == jcse_pkg::SYM_ZRL
         |-> !rsp_last_of_run && rsp_extra_length == '0)
      else $error("ZRL closes an item or carries bits");

   a_len_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_extra_length == rsp_symbol[3:0])
      else $error("extra length differs from size nibble");

   a_bits_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_extra_bits >> rsp_extra_length) == '0)
      else $error("extra bits exceed their length");

endmodule

bind jpeg_coefficient_symbol_encoder_top jcse_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_symbol       (rsp_symbol),
   .rsp_is_dc        (rsp_is_dc),
   .rsp_extra_bits   (rsp_extra_bits),
   .rsp_extra_length (rsp_extra_length),
   .rsp_last_of_run  (rsp_last_of_run)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JPEG coefficient symbol encoder. Streams whole
// 64-coefficient blocks, predicts the DC category, ZRL, AC run/size and EOB
// symbols of each item, and checks each result in order under random idling
// and a long result-side hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_GROUP    = 16;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 250;
   localparam int CYCLE_LIMIT  = 200000;

   typedef logic signed [jcse_pkg::COEFF_BITS-1:0] coeff_type;

   typedef struct {
      logic [jcse_pkg::SYM_BITS-1:0]   symbol;
      logic                            is_dc;
      logic [jcse_pkg::COEFF_BITS-1:0] extra_bits;
      logic [jcse_pkg::SIZE_BITS-1:0]  extra_length;
      logic                            closes_item;
   } symbol_entry_type;

   logic                            clock             = 1'b0;
   logic                            reset             = 1'b1;
   logic                            req_valid         = 1'b0;
   logic                            req_ready;
   coeff_type                       req_coefficient   = '0;
   coeff_type                       req_dc_prediction = '0;
   logic                            rsp_valid;
   logic                            rsp_ready         = 1'b0;
   logic [jcse_pkg::SYM_BITS-1:0]   rsp_symbol;
   logic                            rsp_is_dc;
   logic [jcse_pkg::COEFF_BITS-1:0] rsp_extra_bits;
   logic [jcse_pkg::SIZE_BITS-1:0]  rsp_extra_length;
   logic                            rsp_last_of_run;

   jpeg_coefficient_symbol_encoder_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coefficient  (req_coefficient),
      .req_dc_prediction(req_dc_prediction),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_is_dc        (rsp_is_dc),
      .rsp_extra_bits   (rsp_extra_bits),
      .rsp_extra_length (rsp_extra_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [jcse_pkg::POS_BITS-1:0] block_pos     = '0;
   int                            pending_zeros = 0;
   symbol_entry_type              expected_symbols[$];

   coeff_type block_buf[64];
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_asked    = 0;
   int        hold_served   = 0;
   int        hold_left     = 0;
   int        failures      = 0;
   int        cycle_count   = 0;

   function automatic symbol_entry_type marker_entry(
      input logic [jcse_pkg::SYM_BITS-1:0] sym);
      symbol_entry_type e;
      e.symbol       = sym;
      e.is_dc        = 1'b0;
      e.extra_bits   = '0;
      e.extra_length = '0;
      e.closes_item  = 1'b0;
      return e;
   endfunction

   function automatic symbol_entry_type size_entry(input int value, input int run,
                                                   input logic dc);
      symbol_entry_type e;
      int mag;
      int sz;
      mag = (value < 0) ? -value : value;
      sz  = 0;
      while ((mag >> sz) != 0) sz++;
      e.symbol       = dc ? jcse_pkg::SYM_BITS'(sz)
                          : jcse_pkg::SYM_BITS'(((run << 4) & 'hF0) | (sz & 'h0F));
      e.is_dc        = dc;
      // negative values: ones'-complement index within sz bits
      e.extra_bits   = jcse_pkg::COEFF_BITS'((value < 0) ? ((1 << sz) - 1) - mag : mag);
      e.extra_length = jcse_pkg::SIZE_BITS'(sz);
      e.closes_item  = 1'b0;
      return e;
   endfunction

   function automatic void predict_symbols(input coeff_type coef, input coeff_type pred);
      symbol_entry_type batch[$];
      int run;
      if (block_pos == '0) begin
         batch.push_back(size_entry(int'(coef) - int'(pred), 0, 1'b1));
         pending_zeros = 0;
      end else if (coef == '0) begin
         pending_zeros++;
         if (block_pos == jcse_pkg::LAST_POS) begin
            batch.push_back(marker_entry(jcse_pkg::SYM_EOB));
            pending_zeros = 0;
         end
      end else begin
         run = pending_zeros;
         while (run >= RUN_GROUP) begin
            batch.push_back(marker_entry(jcse_pkg::SYM_ZRL));
            run -= RUN_GROUP;
         end
         batch.push_back(size_entry(int'(coef), run, 1'b0));
         pending_zeros = 0;
      end
      if (batch.size() > 0) batch[batch.size()-1].closes_item = 1'b1;
      foreach (batch[i]) expected_symbols.push_back(batch[i]);
      block_pos++;
   endfunction

   function automatic coeff_type random_nonzero();
      int pick;
      int mag;
      pick = $urandom_range(99);
      if (pick < 60) mag = $urandom_range(15, 1);
      else if (pick < 85) mag = $urandom_range(255, 16);
      else mag = $urandom_range(2047, 256);
      if (pick >= 97) return coeff_type'(-2048);
      return coeff_type'($urandom_range(1) ? -mag : mag);
   endfunction

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         rsp_ready   <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_asked;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      symbol_entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_symbols.size() == 0) begin
            $error("unexpected result: symbol %h", rsp_symbol);
            failures++;
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_symbol !== want.symbol) begin
               $error("symbol: expected %h, actual %h", want.symbol, rsp_symbol);
               failures++;
            end
            if (rsp_is_dc !== want.is_dc) begin
               $error("is_dc: expected %b, actual %b", want.is_dc, rsp_is_dc);
               failures++;
            end
            if (rsp_extra_bits !== want.extra_bits) begin
               $error("extra_bits: expected %h, actual %h", want.extra_bits, rsp_extra_bits);
               failures++;
            end
            if (rsp_extra_length !== want.extra_length) begin
               $error("extra_length: expected %0d, actual %0d",
                      want.extra_length, rsp_extra_length);
               failures++;
            end
            if (rsp_last_of_run !== want.closes_item) begin
               $error("last_of_run: expected %b, actual %b",
                      want.closes_item, rsp_last_of_run);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // called at a rising edge; returns at the edge that accepts the item
   task automatic send_item(input coeff_type coef, input coeff_type pred);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_coefficient   <= coef;
      req_dc_prediction <= pred;
      do @(posedge clock); while (!req_ready);
      predict_symbols(coef, pred);
   endtask

   // block_buf[0] is the DC term; predictions at AC positions are noise
   task automatic send_block(input coeff_type dc_pred);
      for (int p = 0; p < 64; p++) begin
         send_item(block_buf[p], (p == 0) ? dc_pred : coeff_type'($urandom_range(4095)));
      end
   endtask

   task automatic clear_block();
      foreach (block_buf[i]) block_buf[i] = '0;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // zero DC difference, all-zero AC: category 0 then a lone EOB
   task automatic test_empty_block();
      clear_block();
      send_block('0);
   endtask

   // widest DC difference, AC extremes, one exact ZRL group, a run of 15,
   // and a nonzero last term after a ZRL
   task automatic test_extreme_values();
      clear_block();
      block_buf[0]  = coeff_type'(2047);
      block_buf[1]  = coeff_type'(1);
      block_buf[2]  = coeff_type'(-1);
      block_buf[3]  = coeff_type'(2047);
      block_buf[4]  = coeff_type'(-2048);
      block_buf[21] = coeff_type'(5);
      block_buf[37] = coeff_type'(1);
      block_buf[63] = coeff_type'(-1);
      send_block(coeff_type'(-2048));
   endtask

   // most negative DC difference; 62 zeros then a value: three ZRLs and a symbol
   task automatic test_longest_zero_run();
      clear_block();
      block_buf[0]  = coeff_type'(-2048);
      block_buf[63] = coeff_type'(3);
      send_block(coeff_type'(2047));
   endtask

   task automatic test_random_blocks(input int count);
      int        style;
      int        nz_pct;
      coeff_type pred;
      for (int b = 0; b < count; b++) begin
         style = $urandom_range(3);
         pred  = coeff_type'($urandom_range(4095));
         block_buf[0] = ($urandom_range(7) == 0) ? pred : coeff_type'($urandom_range(4095));
         for (int p = 1; p < 64; p++) begin
            case (style)
               0: nz_pct = 5;
               1: nz_pct = 30;
               2: nz_pct = 90;
               default: nz_pct = (p < 20) ? 80 : 0;
            endcase
            block_buf[p] = ($urandom_range(99) < nz_pct) ? random_nonzero()
                                                         : coeff_type'(0);
         end
         send_block(pred);
      end
   endtask

   // result side held off while a dense block streams in
   task automatic test_backpressure();
      hold_asked++;
      block_buf[0] = coeff_type'($urandom_range(4095));
      for (int p = 1; p < 64; p++) begin
         block_buf[p] = ($urandom_range(9) == 0) ? coeff_type'(0) : random_nonzero();
      end
      send_block(coeff_type'($urandom_range(4095)));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(21, 85);
      test_empty_block();
      test_extreme_values();
      test_longest_zero_run();
      wait_for_drain();

      set_idling(85, 21);
      test_random_blocks(1);
      wait_for_drain();

      set_idling(0, 0);
      test_backpressure();
      wait_for_drain();

      if (failures == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
